// ===== sv/srn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srn_pkg: shared types and constants for the sparse row normalizer
// Field widths, fixed-point limits, command/status codes and sequencer states.
// ----------------------------------------------------------------------------
package srn_pkg;

	localparam int VALUE_BITS   = 32;
	localparam int FRAC_BITS    = 16;
	localparam int IDX_BITS     = 10;
	localparam int MAX_ROWS     = 2 ** IDX_BITS;
	localparam int COUNT_BITS   = 21;
	localparam int CMD_BITS     = 2;
	localparam int STAT_BITS    = 2;
	localparam int HI_SHIFT     = VALUE_BITS - FRAC_BITS;
	localparam int DIV_CNT_BITS = $clog2(VALUE_BITS);

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [IDX_BITS-1:0]   idx_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [CMD_BITS-1:0]   cmd_t;
	typedef logic [STAT_BITS-1:0]  stat_t;

	localparam value_t POS_LIMIT = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam value_t NEG_LIMIT = {1'b1, {(VALUE_BITS-1){1'b0}}};
	// 1.0, or the largest positive value where 1.0 does not fit
	localparam value_t ONE_FIX   = (FRAC_BITS < VALUE_BITS - 1) ?
		(value_t'(1) << FRAC_BITS) : POS_LIMIT;
	localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};

	localparam cmd_t CMD_RECORD = 2'd0;
	localparam cmd_t CMD_XFORM  = 2'd1;
	localparam cmd_t CMD_CLEAR  = 2'd2;

	localparam stat_t STAT_OK     = 2'd0;
	localparam stat_t STAT_NODIAG = 2'd1;
	localparam stat_t STAT_SAT    = 2'd2;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK,
		ST_DIVW,
		ST_FIN,
		ST_EMIT
	} state_t;

	// write port of the diagonal table
	typedef struct packed {
		logic   en;
		idx_t   addr;
		logic   seen;
		value_t data;
	} mem_wr_t;

endpackage

// ===== sv/srn_diag_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srn_diag_mem: per-row diagonal table
// One entry per row holding a seen mark and the stored diagonal value.
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module srn_diag_mem (
	input  logic                         clk,
	input  srn_pkg::idx_t                rd_addr,
	input  srn_pkg::mem_wr_t             wr,
	output logic [srn_pkg::VALUE_BITS:0] rd_data
);

	logic [srn_pkg::VALUE_BITS:0] mem [srn_pkg::MAX_ROWS];
	logic [srn_pkg::VALUE_BITS:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= {wr.seen, wr.data};
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ===== sv/srn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srn_div: radix-2 restoring divider for fixed-point quotients
// Computes (num << FRAC_BITS) / den on magnitudes, one quotient bit per cycle.
// Caller guarantees the quotient fits in VALUE_BITS (num >> HI_SHIFT < den).
// ----------------------------------------------------------------------------
module srn_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  srn_pkg::value_t num,
	input  srn_pkg::value_t den,
	output logic            done,
	output srn_pkg::value_t quot
);

	srn_pkg::value_t                   rem_q;
	srn_pkg::value_t                   dq_q;
	srn_pkg::value_t                   den_q;
	logic [srn_pkg::DIV_CNT_BITS-1:0]  cnt_q;
	logic                              busy_q;
	logic                              done_q;

	logic [srn_pkg::VALUE_BITS:0]      trial;
	logic [srn_pkg::VALUE_BITS:0]      diff;
	logic                              ge;

	assign trial = {rem_q, dq_q[srn_pkg::VALUE_BITS-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= srn_pkg::DIV_CNT_BITS'(srn_pkg::VALUE_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// dividend low bits shift out of dq_q while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num >> srn_pkg::HI_SHIFT;
			dq_q  <= num << srn_pkg::FRAC_BITS;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[srn_pkg::VALUE_BITS-1:0] : trial[srn_pkg::VALUE_BITS-1:0];
			dq_q  <= {dq_q[srn_pkg::VALUE_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = dq_q;

endmodule

// ===== sv/sparse_row_normalize_with_pins_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_row_normalize_with_pins_top: two-pass sparse row normalizer
// Record pass stores row diagonals; transform pass rewrites each entry
// (pinned rows keep only the diagonal as 1.0, free rows divide by the
// diagonal) and tags every kept entry with a running count.
//
//  - Input channel (in_valid/in_stall) carries one entry per transaction:
//    command, column, row, value (Q16.16), row_pinned.
//  - Output channel (out_valid/out_stall) carries one result per kept
//    transform entry; records, clears and dropped entries give none.
//  - One transaction at a time. Record and dropped entries pass through the
//    lookup step only; trivial transform entries go from lookup to emit.
//    A free entry that needs a division goes through lookup, divider wait,
//    finish and emit: the shared radix-2 divider produces one quotient bit
//    per cycle. A clear command sweeps all 1024 rows of the diagonal table,
//    one row per cycle.
//  - After reset the same sweep runs; in_stall stays high until
//    it finishes. The kept count starts at zero.
//  - The result sits in an output register; while out_stall is high it
//    holds, and the block still takes the next input transaction, stalling
//    only when a second result is ready before the first is taken.
// ----------------------------------------------------------------------------
module sparse_row_normalize_with_pins_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [srn_pkg::CMD_BITS-1:0]        command,
	input  logic [srn_pkg::IDX_BITS-1:0]        column,
	input  logic [srn_pkg::IDX_BITS-1:0]        row,
	input  logic signed [srn_pkg::VALUE_BITS-1:0] value,
	input  logic                                row_pinned,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [srn_pkg::IDX_BITS-1:0]        out_column,
	output logic [srn_pkg::IDX_BITS-1:0]        out_row,
	output logic signed [srn_pkg::VALUE_BITS-1:0] out_value,
	output logic [srn_pkg::COUNT_BITS-1:0]      kept_count,
	output logic [srn_pkg::STAT_BITS-1:0]       status
);

	srn_pkg::state_t  state_q, state_d;
	srn_pkg::idx_t    clr_q;
	srn_pkg::count_t  kept_q;

	srn_pkg::cmd_t    cmd_q;
	srn_pkg::idx_t    col_q;
	srn_pkg::idx_t    row_q;
	srn_pkg::value_t  val_q;
	logic             pin_q;
	logic             neg_q;
	srn_pkg::value_t  res_q;
	srn_pkg::stat_t   stat_q;

	logic             out_valid_q;
	srn_pkg::idx_t    out_col_q;
	srn_pkg::idx_t    out_row_q;
	srn_pkg::value_t  out_val_q;
	srn_pkg::count_t  out_cnt_q;
	srn_pkg::stat_t   out_stat_q;

	logic [srn_pkg::VALUE_BITS:0] rd_data;
	srn_pkg::mem_wr_t mem_wr;

	logic             accept;
	logic             out_free;
	logic             seen;
	srn_pkg::value_t  diag;
	srn_pkg::value_t  n_mag;
	srn_pkg::value_t  d_mag;
	logic             neg;
	logic             on_diag;
	logic             no_diag;
	logic             pre_sat;

	logic             div_start;
	logic             div_done;
	srn_pkg::value_t  quot;
	srn_pkg::value_t  q_lim;

	logic             res_we;
	srn_pkg::value_t  res_d;
	srn_pkg::stat_t   stat_d;
	logic             load_out;
	logic             clr_start;
	srn_pkg::count_t  kept_next;

	srn_diag_mem u_mem (
		.clk     (clk),
		.rd_addr (row),
		.wr      (mem_wr),
		.rd_data (rd_data)
	);

	srn_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (n_mag),
		.den    (d_mag),
		.done   (div_done),
		.quot   (quot)
	);

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign seen    = rd_data[srn_pkg::VALUE_BITS];
	assign diag    = rd_data[srn_pkg::VALUE_BITS-1:0];
	assign n_mag   = val_q[srn_pkg::VALUE_BITS-1] ? srn_pkg::value_t'(-val_q) : val_q;
	assign d_mag   = diag[srn_pkg::VALUE_BITS-1] ? srn_pkg::value_t'(-diag) : diag;
	assign neg     = val_q[srn_pkg::VALUE_BITS-1] ^ diag[srn_pkg::VALUE_BITS-1];
	assign on_diag = row_q == col_q;
	assign no_diag = !seen || (diag == '0);
	// quotient would not fit in VALUE_BITS: saturates without dividing
	assign pre_sat = (n_mag >> srn_pkg::HI_SHIFT) >= d_mag;

	assign q_lim     = neg_q ? srn_pkg::NEG_LIMIT : srn_pkg::POS_LIMIT;
	assign kept_next = (kept_q == srn_pkg::COUNT_MAX) ? kept_q : kept_q + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srn_pkg::ST_CLEAR: begin
				if (clr_q == srn_pkg::idx_t'(srn_pkg::MAX_ROWS - 1)) begin
					state_d = srn_pkg::ST_IDLE;
				end
			end
			srn_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = srn_pkg::ST_LOOK;
				end
			end
			srn_pkg::ST_LOOK: begin
				unique case (cmd_q)
					srn_pkg::CMD_CLEAR: state_d = srn_pkg::ST_CLEAR;
					srn_pkg::CMD_XFORM: begin
						if (pin_q) begin
							state_d = on_diag ? srn_pkg::ST_EMIT : srn_pkg::ST_IDLE;
						end else if (no_diag || pre_sat) begin
							state_d = srn_pkg::ST_EMIT;
						end else begin
							state_d = srn_pkg::ST_DIVW;
						end
					end
					default: state_d = srn_pkg::ST_IDLE;
				endcase
			end
			srn_pkg::ST_DIVW: begin
				if (div_done) begin
					state_d = srn_pkg::ST_FIN;
				end
			end
			srn_pkg::ST_FIN: state_d = srn_pkg::ST_EMIT;
			srn_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = srn_pkg::ST_IDLE;
				end
			end
			default: state_d = srn_pkg::ST_CLEAR;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = 1'b1;
		mem_wr    = '0;
		div_start = 1'b0;
		res_we    = 1'b0;
		res_d     = '0;
		stat_d    = srn_pkg::STAT_OK;
		load_out  = 1'b0;
		clr_start = 1'b0;
		unique case (state_q)
			srn_pkg::ST_CLEAR: begin
				mem_wr.en   = 1'b1;
				mem_wr.addr = clr_q;
			end
			srn_pkg::ST_IDLE: in_stall = 1'b0;
			srn_pkg::ST_LOOK: begin
				unique case (cmd_q)
					srn_pkg::CMD_RECORD: begin
						// first diagonal since the last clear wins
						mem_wr.en   = on_diag && !seen;
						mem_wr.addr = row_q;
						mem_wr.seen = 1'b1;
						mem_wr.data = val_q;
					end
					srn_pkg::CMD_CLEAR: clr_start = 1'b1;
					srn_pkg::CMD_XFORM: begin
						res_we = 1'b1;
						if (pin_q) begin
							res_d = srn_pkg::ONE_FIX;
						end else if (no_diag) begin
							stat_d = srn_pkg::STAT_NODIAG;
						end else if (pre_sat) begin
							res_d  = neg ? srn_pkg::NEG_LIMIT : srn_pkg::POS_LIMIT;
							stat_d = srn_pkg::STAT_SAT;
						end else begin
							div_start = 1'b1;
						end
					end
					default: ;
				endcase
			end
			srn_pkg::ST_DIVW: ;
			srn_pkg::ST_FIN: begin
				res_we = 1'b1;
				if (quot > q_lim) begin
					res_d  = q_lim;
					stat_d = srn_pkg::STAT_SAT;
				end else begin
					res_d = neg_q ? srn_pkg::value_t'(-quot) : quot;
				end
			end
			srn_pkg::ST_EMIT: load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srn_pkg::ST_CLEAR;
			clr_q       <= '0;
			kept_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_start) begin
				clr_q  <= '0;
				kept_q <= '0;
			end else if (state_q == srn_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end else if (load_out) begin
				kept_q <= kept_next;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			col_q <= column;
			row_q <= row;
			val_q <= srn_pkg::value_t'(value);
			pin_q <= row_pinned;
		end
		if (div_start) begin
			neg_q <= neg;
		end
		if (res_we) begin
			res_q  <= res_d;
			stat_q <= stat_d;
		end
		if (load_out) begin
			out_col_q  <= col_q;
			out_row_q  <= row_q;
			out_val_q  <= res_q;
			out_cnt_q  <= kept_next;
			out_stat_q <= stat_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_column = out_col_q;
	assign out_row    = out_row_q;
	assign out_value  = $signed(out_val_q);
	assign kept_count = out_cnt_q;
	assign status     = out_stat_q;

`ifndef SYNTHESIS
	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == srn_pkg::ST_EMIT))
		else $error("result appeared outside the emit step");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_cnt_q != '0)
		else $error("kept count of a result is zero");

	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srn_pkg::ST_CLEAR) |-> kept_q == '0)
		else $error("kept count not cleared during table sweep");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == srn_pkg::ST_DIVW)
		else $error("divider finished while sequencer not waiting");
`endif

endmodule
